[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form with explicit clock and reset
`define JT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// house form on the block clock and reset
`define JT_ASSERT_CLK(label, prop, msg) \
   `JT_ASSERT(label, clock, reset, prop, msg)

`endif

[rtl/jtdm_pkg.sv]
`timescale 1ns / 1ps

package jtdm_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int PC_W        = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_REST,
      CSR_Y_REST,
      CSR_SPEED_LIMIT,
      CSR_SLEW_STEP
   } csr_index_type;

   // datapath operation of one microcode step
   typedef enum logic [2:0] {
      OP_WAIT,
      OP_SETUP,
      OP_DIV,
      OP_STORE,
      OP_SLEW,
      OP_EMIT
   } op_type;

   // operand source / destination of setup and store
   typedef enum logic [1:0] {
      SEL_Y,
      SEL_X,
      SEL_T
   } sel_type;

   // condition that lets the step counter move to next_pc
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_ITER,
      COND_OUT
   } cond_type;

   typedef struct packed {
      op_type          op;
      sel_type         sel;
      cond_type        cond;
      logic [PC_W-1:0] next_pc;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_WAIT, sel: SEL_Y, cond: COND_REQ, next_pc: PC_W'(1)};
      case (pc)
         PC_W'(0):  w = '{op: OP_WAIT,  sel: SEL_Y, cond: COND_REQ,    next_pc: PC_W'(1)};
         PC_W'(1):  w = '{op: OP_SETUP, sel: SEL_Y, cond: COND_ALWAYS, next_pc: PC_W'(2)};
         PC_W'(2):  w = '{op: OP_DIV,   sel: SEL_Y, cond: COND_ITER,   next_pc: PC_W'(3)};
         PC_W'(3):  w = '{op: OP_STORE, sel: SEL_Y, cond: COND_ALWAYS, next_pc: PC_W'(4)};
         PC_W'(4):  w = '{op: OP_SETUP, sel: SEL_X, cond: COND_ALWAYS, next_pc: PC_W'(5)};
         PC_W'(5):  w = '{op: OP_DIV,   sel: SEL_X, cond: COND_ITER,   next_pc: PC_W'(6)};
         PC_W'(6):  w = '{op: OP_STORE, sel: SEL_X, cond: COND_ALWAYS, next_pc: PC_W'(7)};
         PC_W'(7):  w = '{op: OP_SETUP, sel: SEL_T, cond: COND_ALWAYS, next_pc: PC_W'(8)};
         PC_W'(8):  w = '{op: OP_DIV,   sel: SEL_T, cond: COND_ITER,   next_pc: PC_W'(9)};
         PC_W'(9):  w = '{op: OP_STORE, sel: SEL_T, cond: COND_ALWAYS, next_pc: PC_W'(10)};
         PC_W'(10): w = '{op: OP_SLEW,  sel: SEL_Y, cond: COND_ALWAYS, next_pc: PC_W'(11)};
         PC_W'(11): w = '{op: OP_EMIT,  sel: SEL_Y, cond: COND_OUT,    next_pc: PC_W'(0)};
         default:   w = '{op: OP_WAIT,  sel: SEL_Y, cond: COND_ALWAYS, next_pc: PC_W'(0)};
      endcase
      return w;
   endfunction

endpackage

[rtl/joystick_tank_drive_mixer.sv]
`timescale 1ns / 1ps

// Tank-drive mixer: one request (x_pos, y_pos) in, one response out with
// left/right motor direction and level plus the indicator colour. Each
// axis is split about its center register into a 0..255 magnitude by
// truncating scale d*255/span (saturating when the offset reaches the
// span); the common speed is slew-limited by the slew step register against
// the previous speed, then clamped to +-speed limit; turn is the x magnitude
// divided by TURN_DIVISOR toward zero. A microcode program of twelve
// steps runs three divisions (y axis, x axis, turn) on one shared
// restoring divider at one quotient bit per cycle, with a setup and a
// store step around each division, then one slew step and one load
// step. A new request is taken only in the wait step, so none is taken
// before the previous one has left the load step. A response that is not
// taken holds the sequencer in its load step, which keeps the request
// channel blocked until it leaves. The response register holds a result
// while the next request is accepted. Configuration is to be written by
// the user through csr_we / csr_index / csr_wdata only while no request
// is in flight; the block itself does not enforce this.
module joystick_tank_drive_mixer import jtdm_pkg::*; #(
   parameter int FULL_SCALE   = 1023,
   parameter int TURN_DIVISOR = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [9:0]             req_x_pos,
   input  logic [9:0]             req_y_pos,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_left_reverse,
   output logic [7:0]             rsp_left_level,
   output logic                   rsp_right_reverse,
   output logic [7:0]             rsp_right_level,
   output logic [7:0]             rsp_led_red,
   output logic [7:0]             rsp_led_green,
   output logic [7:0]             rsp_led_blue
);

   // divisor width: enough for the full-scale span and for a 10-bit center
   localparam int FS_W = $clog2(FULL_SCALE + 1);
   localparam int DW   = (FS_W > 10) ? FS_W : 10;
   // signed span, may go negative when a center sits above full scale
   localparam int SW   = DW + 1;
   // divider working width: dividend up to 1023*255, divisor shifted by 7
   localparam int CW   = (DW + 7 > 18) ? DW + 7 : 18;
   localparam logic signed [SW-1:0] FS_S = SW'(FULL_SCALE);

   // configuration registers
   logic [9:0] x_rest_ff, x_rest_in;
   logic [9:0] y_rest_ff, y_rest_in;
   logic [7:0] speed_limit_ff, speed_limit_in;
   logic [7:0] slew_step_ff, slew_step_in;

   // sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_word_type   ctrl;
   logic            step_go;
   logic            out_free;

   // latched request
   logic [9:0] x_pos_ff, x_pos_in;
   logic [9:0] y_pos_ff, y_pos_in;

   // shared divider
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] dsh_ff, dsh_in;
   logic [7:0]    quot_ff, quot_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          zero_ff, zero_in;
   logic          sat_ff, sat_in;
   logic          pos_ff, pos_in;

   // magnitudes and speed state
   logic [7:0]        fwd_ff, fwd_in;
   logic [7:0]        bwd_ff, bwd_in;
   logic [7:0]        lft_ff, lft_in;
   logic [7:0]        rgt_ff, rgt_in;
   logic [7:0]        turn_ff, turn_in;
   logic              turn_neg_ff, turn_neg_in;
   logic signed [8:0] prev_speed_ff, prev_speed_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       left_rev_ff, left_rev_in;
   logic [7:0] left_lvl_ff, left_lvl_in;
   logic       right_rev_ff, right_rev_in;
   logic [7:0] right_lvl_ff, right_lvl_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;

   // setup operands
   logic [9:0]           axis_pos, axis_ctr, axis_d;
   logic                 axis_up;
   logic signed [SW-1:0] span_s, d_s;
   logic [7:0]           tmag;
   logic [CW-1:0]        setup_dividend;
   logic [DW-1:0]        setup_dvsr;
   logic                 setup_zero, setup_sat, setup_pos;

   // divider step and store value
   logic       div_ge;
   logic [7:0] div_res;

   // speed arithmetic
   logic signed [10:0] prev_x, msc_x, ms_x, spd_raw, diff, lim, clamped;
   logic signed [10:0] turn_s, ldrv, rdrv;

   // sign bit and saturated magnitude of a drive value
   function automatic logic [8:0] motor(input logic signed [10:0] v);
      logic [10:0] m;
      m = v[10] ? 11'(-v) : 11'(v);
      return {v[10], (m > 11'd255) ? 8'hFF : m[7:0]};
   endfunction

   assign ctrl     = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS: step_go = 1'b1;
         COND_REQ:    step_go = req_valid;
         COND_ITER:   step_go = (cnt_ff == 3'd0);
         COND_OUT:    step_go = out_free;
         default:     step_go = 1'b1;
      endcase
   end

   assign req_ready = (ctrl.op == OP_WAIT);

   // operand selection for a division setup
   always_comb begin
      axis_pos = (ctrl.sel == SEL_X) ? x_pos_ff : y_pos_ff;
      axis_ctr = (ctrl.sel == SEL_X) ? x_rest_ff : y_rest_ff;
      axis_up  = axis_pos > axis_ctr;
      axis_d   = axis_up ? (axis_pos - axis_ctr) : (axis_ctr - axis_pos);
      span_s   = axis_up ? (FS_S - SW'(axis_ctr)) : SW'(axis_ctr);
      d_s      = SW'(axis_d);
      tmag     = lft_ff | rgt_ff;
      if (ctrl.sel == SEL_T) begin
         // only one of left/right is nonzero, so their OR is the x
         // magnitude; which one is set gives the sign
         setup_dividend = CW'(tmag);
         setup_dvsr     = DW'(TURN_DIVISOR);
         setup_zero     = (tmag == 8'd0);
         setup_sat      = 1'b0;
         setup_pos      = (rgt_ff == 8'd0);
      end else begin
         setup_dividend = CW'({axis_d, 8'h00}) - CW'(axis_d);
         setup_dvsr     = span_s[DW-1:0];
         setup_zero     = (axis_d == 10'd0);
         setup_sat      = (d_s >= span_s);
         setup_pos      = axis_up;
      end
   end

   assign div_ge  = (rem_ff >= dsh_ff);
   assign div_res = zero_ff ? 8'h00 : (sat_ff ? 8'hFF : quot_ff);

   // slew limit, then clamp
   always_comb begin
      prev_x  = {{2{prev_speed_ff[8]}}, prev_speed_ff};
      msc_x   = {3'b000, slew_step_ff};
      ms_x    = {3'b000, speed_limit_ff};
      spd_raw = $signed({3'b000, fwd_ff}) - $signed({3'b000, bwd_ff});
      diff    = spd_raw - prev_x;
      if (diff > msc_x) begin
         lim = prev_x + msc_x;
      end else if (diff < -msc_x) begin
         lim = prev_x - msc_x;
      end else begin
         lim = spd_raw;
      end
      if (lim > ms_x) begin
         clamped = ms_x;
      end else if (lim < -ms_x) begin
         clamped = -ms_x;
      end else begin
         clamped = lim;
      end
      turn_s = turn_neg_ff ? -$signed({3'b000, turn_ff}) : $signed({3'b000, turn_ff});
      ldrv   = prev_x + turn_s;
      rdrv   = prev_x - turn_s;
   end

   always_comb begin
      x_rest_in           = x_rest_ff;
      y_rest_in           = y_rest_ff;
      speed_limit_in      = speed_limit_ff;
      slew_step_in        = slew_step_ff;
      pc_in               = step_go ? ctrl.next_pc : pc_ff;
      x_pos_in            = x_pos_ff;
      y_pos_in            = y_pos_ff;
      rem_in              = rem_ff;
      dsh_in              = dsh_ff;
      quot_in             = quot_ff;
      cnt_in              = cnt_ff;
      zero_in             = zero_ff;
      sat_in              = sat_ff;
      pos_in              = pos_ff;
      fwd_in              = fwd_ff;
      bwd_in              = bwd_ff;
      lft_in              = lft_ff;
      rgt_in              = rgt_ff;
      turn_in             = turn_ff;
      turn_neg_in         = turn_neg_ff;
      prev_speed_in       = prev_speed_ff;
      rsp_valid_in        = rsp_ready ? 1'b0 : rsp_valid_ff;
      left_rev_in         = left_rev_ff;
      left_lvl_in         = left_lvl_ff;
      right_rev_in        = right_rev_ff;
      right_lvl_in        = right_lvl_ff;
      red_in              = red_ff;
      green_in            = green_ff;
      blue_in             = blue_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_X_REST:      x_rest_in      = csr_wdata;
            CSR_Y_REST:      y_rest_in      = csr_wdata;
            CSR_SPEED_LIMIT: speed_limit_in = csr_wdata[7:0];
            CSR_SLEW_STEP:   slew_step_in   = csr_wdata[7:0];
            default:         ;
         endcase
      end

      unique case (ctrl.op)
         OP_WAIT: begin
            if (req_valid) begin
               x_pos_in = req_x_pos;
               y_pos_in = req_y_pos;
            end
         end
         OP_SETUP: begin
            rem_in  = setup_dividend;
            dsh_in  = CW'({setup_dvsr, 7'b0000000});
            quot_in = 8'h00;
            cnt_in  = 3'd7;
            zero_in = setup_zero;
            sat_in  = setup_sat;
            pos_in  = setup_pos;
         end
         OP_DIV: begin
            // one restoring step, msb of the quotient first
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quot_in = {quot_ff[6:0], div_ge};
            dsh_in  = dsh_ff >> 1;
            cnt_in  = cnt_ff - 3'd1;
         end
         OP_STORE: begin
            case (ctrl.sel)
               SEL_Y: begin
                  fwd_in = pos_ff ? div_res : 8'h00;
                  bwd_in = pos_ff ? 8'h00 : div_res;
               end
               SEL_X: begin
                  lft_in = pos_ff ? div_res : 8'h00;
                  rgt_in = pos_ff ? 8'h00 : div_res;
               end
               default: begin
                  turn_in     = div_res;
                  turn_neg_in = !pos_ff;
               end
            endcase
         end
         OP_SLEW: begin
            prev_speed_in = clamped[8:0];
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               {left_rev_in, left_lvl_in}   = motor(ldrv);
               {right_rev_in, right_lvl_in} = motor(rdrv);
               red_in   = bwd_ff;
               green_in = lft_ff + rgt_ff;
               blue_in  = fwd_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_rest_ff      <= 10'd524;
         y_rest_ff      <= 10'd513;
         speed_limit_ff <= 8'd150;
         slew_step_ff   <= 8'd5;
         pc_ff          <= '0;
         prev_speed_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         x_rest_ff      <= x_rest_in;
         y_rest_ff      <= y_rest_in;
         speed_limit_ff <= speed_limit_in;
         slew_step_ff   <= slew_step_in;
         pc_ff          <= pc_in;
         prev_speed_ff  <= prev_speed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      // payload, no reset needed
      x_pos_ff     <= x_pos_in;
      y_pos_ff     <= y_pos_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      zero_ff      <= zero_in;
      sat_ff       <= sat_in;
      pos_ff       <= pos_in;
      fwd_ff       <= fwd_in;
      bwd_ff       <= bwd_in;
      lft_ff       <= lft_in;
      rgt_ff       <= rgt_in;
      turn_ff      <= turn_in;
      turn_neg_ff  <= turn_neg_in;
      left_rev_ff  <= left_rev_in;
      left_lvl_ff  <= left_lvl_in;
      right_rev_ff <= right_rev_in;
      right_lvl_ff <= right_lvl_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_reverse  = left_rev_ff;
   assign rsp_left_level    = left_lvl_ff;
   assign rsp_right_reverse = right_rev_ff;
   assign rsp_right_level   = right_lvl_ff;
   assign rsp_led_red       = red_ff;
   assign rsp_led_green     = green_ff;
   assign rsp_led_blue      = blue_ff;

endmodule

[rtl/jtdm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jtdm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_left_reverse,
   input logic [7:0] rsp_left_level,
   input logic       rsp_right_reverse,
   input logic [7:0] rsp_right_level,
   input logic [7:0] rsp_led_red,
   input logic [7:0] rsp_led_blue
);

   // sequencer is busy right after taking a request
   `JT_ASSERT_CLK(a_busy_after_req, req_valid && req_ready |=> !req_ready,
      "ready after accept")

   // stalled response holds
   `JT_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_left_level) && $stable(rsp_right_level),
      "stalled response changed")

   // a reverse drive is never of zero level
   `JT_ASSERT_CLK(a_rev_level, rsp_valid && (rsp_left_reverse || rsp_right_reverse) |->
      (!rsp_left_reverse || rsp_left_level != 8'd0) &&
      (!rsp_right_reverse || rsp_right_level != 8'd0),
      "reverse with zero level")

   // forward and backward never both lit
   `JT_ASSERT_CLK(a_led_excl, rsp_valid && rsp_led_red != 8'd0 |-> rsp_led_blue == 8'd0,
      "red and blue both lit")

endmodule

bind joystick_tank_drive_mixer jtdm_checker u_jtdm_checker (.*);
